// File: hdl/pcsb_pkg.sv
// Shared constants, codes and tables of the point-to-scan binner.
// Used by the top level and the checker; depends on nothing else.
package pcsb_pkg;

    localparam int NUM_BINS      = 256;
    localparam int BIN_AW        = $clog2(NUM_BINS);
    localparam int CW            = 18;   // coordinate and register width
    localparam int ANG_W         = 20;   // signed angle accumulator
    localparam int CX_W          = 34;   // signed CORDIC vector width
    localparam int SQ_W          = 36;   // x*x + y*y
    localparam int RT_W          = 18;   // planar range
    localparam int Q_W           = 19;   // bin dividend and quotient
    localparam int CNT_W         = 5;
    localparam int CORDIC_STEPS  = 16;
    localparam int CORDIC_SHIFT  = 12;
    localparam int SQRT_STEPS    = 18;
    localparam int MEM_W         = RT_W + 8;

    localparam logic [ANG_W-1:0] HALF_PI_Q16 = ANG_W'(102944);
    localparam logic [RT_W-1:0]  NEAR_RANGE  = RT_W'(800);
    localparam logic [7:0]       NEAR_MIN    = 8'd200;
    localparam logic [7:0]       FAR_MIN     = 8'd120;

    // item selector
    localparam logic [1:0] FN_POINT = 2'd0;
    localparam logic [1:0] FN_READ  = 2'd1;
    localparam logic [1:0] FN_CLEAR = 2'd2;

    // reject codes
    localparam logic [2:0] RJ_PASS      = 3'd0;
    localparam logic [2:0] RJ_INVALID   = 3'd1;
    localparam logic [2:0] RJ_CONF      = 3'd2;
    localparam logic [2:0] RJ_HEIGHT    = 3'd3;
    localparam logic [2:0] RJ_ANGLE     = 3'd4;
    localparam logic [2:0] RJ_RANGE     = 3'd5;
    localparam logic [2:0] RJ_INTENSITY = 3'd6;
    localparam logic [2:0] RJ_BEYOND    = 3'd7;

    // register indexes
    localparam logic [2:0] CFG_MIN_CONF   = 3'd0;
    localparam logic [2:0] CFG_Z_LOW      = 3'd1;
    localparam logic [2:0] CFG_Z_HIGH     = 3'd2;
    localparam logic [2:0] CFG_ANGLE_LIM  = 3'd3;
    localparam logic [2:0] CFG_BIN_WIDTH  = 3'd4;
    localparam logic [2:0] CFG_RANGE_LOW  = 3'd5;
    localparam logic [2:0] CFG_RANGE_HIGH = 3'd6;

    // CORDIC arctangent table, 2^-16 rad
    function automatic logic [ANG_W-1:0] atan_q16(input logic [3:0] i);
        logic [ANG_W-1:0] v;
        case (i)
            4'd0:    v = ANG_W'(51472);
            4'd1:    v = ANG_W'(30386);
            4'd2:    v = ANG_W'(16055);
            4'd3:    v = ANG_W'(8150);
            4'd4:    v = ANG_W'(4091);
            4'd5:    v = ANG_W'(2047);
            4'd6:    v = ANG_W'(1024);
            4'd7:    v = ANG_W'(512);
            4'd8:    v = ANG_W'(256);
            4'd9:    v = ANG_W'(128);
            4'd10:   v = ANG_W'(64);
            4'd11:   v = ANG_W'(32);
            4'd12:   v = ANG_W'(16);
            4'd13:   v = ANG_W'(8);
            4'd14:   v = ANG_W'(4);
            4'd15:   v = ANG_W'(2);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/pcsb_ram.sv
// Generic single-port synchronous RAM with registered read.
// Standalone; used for the bin store of the binner.
module pcsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write or read one entry per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/point_cloud_to_scan_binner.sv
// Point-to-scan binner top level: filters, CORDIC bearing, root, bin divide,
// bin store read-modify-write. Depends on pcsb_pkg and pcsb_ram.
//
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_ready    | func, x/y/z, finite, conf, intensity, read_bin
//  out     | output    | o_out_valid / i_out_ready  | kept, reject_code, bin_number, range, int, empty
//  cfg     | input     | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// One transaction at a time. Read, clear and early rejects skip the iterations;
// a point reaching the bearing stage runs 18 root steps (the 16 CORDIC steps
// run alongside), plus 19 divider steps and the store read and merge when kept.
// Reset is synchronous: it empties all bins and loads the register defaults.
// A stalled output holds the block in its final state; no transaction is lost.
module point_cloud_to_scan_binner
    import pcsb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_func,
    input  logic signed [CW-1:0]  i_x_mm,
    input  logic signed [CW-1:0]  i_y_mm,
    input  logic signed [CW-1:0]  i_z_mm,
    input  logic                  i_finite,
    input  logic [15:0]           i_confidence,
    input  logic [7:0]            i_intensity,
    input  logic [7:0]            i_read_bin,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_kept,
    output logic [2:0]            o_reject_code,
    output logic [7:0]            o_bin_number,
    output logic [RT_W-1:0]       o_bin_range_mm,
    output logic [7:0]            o_bin_intensity,
    output logic                  o_bin_empty,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_index,
    input  logic [CW-1:0]         i_cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FRONT = 7'b0000010,
        S_ITER  = 7'b0000100,
        S_CHK   = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_RD    = 7'b0100000,
        S_MRG   = 7'b1000000
    } t_state;

    // S_OUT is folded: result registers plus a pending flag
    t_state r_state;
    logic   r_pend;

    // configuration
    logic [15:0]          r_min_conf;
    logic signed [CW-1:0] r_zlo, r_zhi;
    logic [CW-1:0]        r_alim, r_bw, r_rlo, r_rhi;

    // captured transaction
    logic [1:0]           r_func;
    logic signed [CW-1:0] r_x, r_y, r_z;
    logic                 r_fin;
    logic [15:0]          r_conf;
    logic [7:0]           r_int, r_rbin;

    // datapath registers
    logic signed [CX_W-1:0]  r_cx, r_cy;
    logic signed [ANG_W-1:0] r_ang;
    logic                    r_origin;
    logic [SQ_W-1:0]         r_sq, r_root, r_bit;
    logic [CNT_W-1:0]        r_cnt;
    logic [CW-1:0]           r_rem;
    logic [Q_W-1:0]          r_quo;
    logic [RT_W-1:0]         r_range;
    logic [BIN_AW-1:0]       r_addr;
    logic [NUM_BINS-1:0]     r_filled;

    // result
    logic            r_kept, r_empty;
    logic [2:0]      r_code;
    logic [7:0]      r_bnum, r_bint;
    logic [RT_W-1:0] r_brange;

    // output register
    logic            r_ov, r_okept, r_oempty;
    logic [2:0]      r_ocode;
    logic [7:0]      r_obnum, r_obint;
    logic [RT_W-1:0] r_obrange;

    // combinational helpers
    logic                    acc_in;
    logic                    out_free;
    logic signed [CX_W-1:0]  ex_x, ex_y, dx, dy;
    logic signed [SQ_W-1:0]  sq_x, sq_y;
    logic signed [ANG_W-1:0] atan_v, lim_s, ang_f, dvd_s;
    logic [SQ_W:0]           trial_sq;
    logic [CW:0]             trial_d;
    logic [CW-1:0]           bw_eff;
    logic [Q_W-1:0]          quo_nx;
    logic [RT_W-1:0]         root_f;
    logic                    rd_beyond, bin_beyond;
    logic                    mem_we;
    logic [MEM_W-1:0]        mem_rdata;
    logic [RT_W-1:0]         mem_range;
    logic [7:0]              mem_int;
    logic                    take_new;

    assign acc_in     = i_in_valid && o_in_ready;
    assign out_free   = !r_ov || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && !r_pend;

    assign ex_x    = CX_W'(r_x);
    assign ex_y    = CX_W'(r_y);
    assign sq_x    = SQ_W'(r_x) * SQ_W'(r_x);
    assign sq_y    = SQ_W'(r_y) * SQ_W'(r_y);
    assign dx      = r_cy >>> r_cnt[3:0];
    assign dy      = r_cx >>> r_cnt[3:0];
    assign atan_v  = signed'(atan_q16(r_cnt[3:0]));
    assign lim_s   = signed'(ANG_W'(r_alim));
    assign ang_f   = r_origin ? '0 : r_ang;
    assign dvd_s   = ang_f + lim_s;
    assign root_f  = r_root[RT_W-1:0];
    assign trial_sq = {1'b0, r_root} + {1'b0, r_bit};
    assign bw_eff  = (r_bw == '0) ? CW'(1) : r_bw;
    assign trial_d = {r_rem, r_quo[Q_W-1]};
    assign quo_nx  = {r_quo[Q_W-2:0], (trial_d >= {1'b0, bw_eff})};
    assign bin_beyond = 32'(quo_nx) >= NUM_BINS;
    assign rd_beyond  = 32'(r_rbin) >= NUM_BINS;
    assign mem_range  = mem_rdata[MEM_W-1:8];
    assign mem_int    = mem_rdata[7:0];
    assign take_new   = !r_filled[r_addr] || (r_range < mem_range);
    assign mem_we     = (r_state == S_MRG) && (r_func == FN_POINT) && take_new;

    // bin store: nearest range and its intensity
    pcsb_ram #(
        .WIDTH (MEM_W),
        .DEPTH (NUM_BINS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (r_addr),
        .i_wdata ({r_range, r_int}),
        .o_rdata (mem_rdata)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_conf <= 16'd30;
            r_zlo      <= -CW'(1000);
            r_zhi      <= CW'(1000);
            r_alim     <= CW'(45748);
            r_bw       <= CW'(572);
            r_rlo      <= CW'(100);
            r_rhi      <= CW'(20000);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MIN_CONF:   r_min_conf <= i_cfg_data[15:0];
                CFG_Z_LOW:      r_zlo      <= signed'(i_cfg_data);
                CFG_Z_HIGH:     r_zhi      <= signed'(i_cfg_data);
                CFG_ANGLE_LIM:  r_alim     <= i_cfg_data;
                CFG_BIN_WIDTH:  r_bw       <= i_cfg_data;
                CFG_RANGE_LOW:  r_rlo      <= i_cfg_data;
                CFG_RANGE_HIGH: r_rhi      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // capture the input transaction
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_func <= i_func;
            r_x    <= i_x_mm;
            r_y    <= i_y_mm;
            r_z    <= i_z_mm;
            r_fin  <= i_finite;
            r_conf <= i_confidence;
            r_int  <= i_intensity;
            r_rbin <= i_read_bin;
        end
    end

    // sequencer and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend   <= 1'b0;
            r_filled <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (acc_in) r_state <= S_FRONT;
                end
                S_FRONT: begin
                    if (r_func == FN_POINT && r_fin && r_conf >= r_min_conf &&
                        r_z >= r_zlo && r_z <= r_zhi) begin
                        r_state <= S_ITER;
                    end else if (r_func == FN_READ && !rd_beyond) begin
                        r_state <= S_RD;
                    end else begin
                        if (r_func == FN_CLEAR) r_filled <= '0;
                        r_pend  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_ITER: begin
                    if (r_cnt == CNT_W'(SQRT_STEPS - 1)) r_state <= S_CHK;
                end
                S_CHK: begin
                    if (ang_f < -lim_s || ang_f > lim_s || root_f < r_rlo ||
                        root_f > r_rhi ||
                        r_int < ((root_f <= NEAR_RANGE) ? NEAR_MIN : FAR_MIN)) begin
                        r_pend  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == CNT_W'(Q_W - 1)) begin
                        if (bin_beyond) begin
                            r_pend  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: r_state <= S_MRG;
                S_MRG: begin
                    if (mem_we) r_filled[r_addr] <= 1'b1;
                    r_pend  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            // hand the result to the output register
            if (r_pend && out_free) r_pend <= 1'b0;
        end
    end

    // datapath: CORDIC, root, divider and result fields
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_FRONT: begin
                r_kept   <= 1'b0;
                r_bnum   <= '0;
                r_brange <= '0;
                r_bint   <= '0;
                r_empty  <= 1'b0;
                r_code   <= RJ_PASS;
                r_cnt    <= '0;
                r_addr   <= BIN_AW'(r_rbin);
                r_origin <= (r_x == '0) && (r_y == '0);
                r_sq     <= unsigned'(sq_x) + unsigned'(sq_y);
                r_root   <= '0;
                r_bit    <= SQ_W'(1) << (SQ_W - 2);
                if (!r_y[CW-1] || !r_x[CW-1]) begin
                    // vector already in right half plane or rotate by -90 with the angle at +90
                    if (!r_x[CW-1]) begin
                        r_cx  <= ex_x <<< CORDIC_SHIFT;
                        r_cy  <= ex_y <<< CORDIC_SHIFT;
                        r_ang <= '0;
                    end else begin
                        r_cx  <= ex_y <<< CORDIC_SHIFT;
                        r_cy  <= (-ex_x) <<< CORDIC_SHIFT;
                        r_ang <= signed'(HALF_PI_Q16);
                    end
                end else begin
                    r_cx  <= (-ex_y) <<< CORDIC_SHIFT;
                    r_cy  <= ex_x <<< CORDIC_SHIFT;
                    r_ang <= -signed'(HALF_PI_Q16);
                end
                if (r_func == FN_POINT) begin
                    if (!r_fin)                        r_code <= RJ_INVALID;
                    else if (r_conf < r_min_conf)      r_code <= RJ_CONF;
                    else if (r_z < r_zlo || r_z > r_zhi) r_code <= RJ_HEIGHT;
                end else if (r_func == FN_READ) begin
                    r_bnum <= r_rbin;
                    if (rd_beyond) begin
                        r_code  <= RJ_BEYOND;
                        r_empty <= 1'b1;
                    end
                end
            end
            S_ITER: begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt < CNT_W'(CORDIC_STEPS)) begin
                    if (!r_cy[CX_W-1]) begin
                        r_cx  <= r_cx + dx;
                        r_cy  <= r_cy - dy;
                        r_ang <= r_ang + atan_v;
                    end else begin
                        r_cx  <= r_cx - dx;
                        r_cy  <= r_cy + dy;
                        r_ang <= r_ang - atan_v;
                    end
                end
                if (r_sq >= trial_sq[SQ_W-1:0]) begin
                    r_sq   <= r_sq - trial_sq[SQ_W-1:0];
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            S_CHK: begin
                r_cnt   <= '0;
                r_range <= root_f;
                r_rem   <= '0;
                r_quo   <= Q_W'(unsigned'(dvd_s));
                if (ang_f < -lim_s || ang_f > lim_s)          r_code <= RJ_ANGLE;
                else if (root_f < r_rlo || root_f > r_rhi)    r_code <= RJ_RANGE;
                else if (r_int < ((root_f <= NEAR_RANGE) ? NEAR_MIN : FAR_MIN))
                    r_code <= RJ_INTENSITY;
            end
            S_DIV: begin
                r_cnt <= r_cnt + CNT_W'(1);
                r_quo <= quo_nx;
                if (trial_d >= {1'b0, bw_eff}) r_rem <= CW'(trial_d - {1'b0, bw_eff});
                else                           r_rem <= trial_d[CW-1:0];
                if (r_cnt == CNT_W'(Q_W - 1)) begin
                    r_kept <= 1'b1;
                    r_bnum <= quo_nx[7:0];
                    r_addr <= quo_nx[BIN_AW-1:0];
                    if (bin_beyond) r_code <= RJ_BEYOND;
                end
            end
            S_MRG: begin
                if (r_func == FN_READ) begin
                    if (r_filled[r_addr]) begin
                        r_brange <= mem_range;
                        r_bint   <= mem_int;
                    end else begin
                        r_empty <= 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_free) begin
            r_ov <= r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend && out_free) begin
            r_okept   <= r_kept;
            r_ocode   <= r_code;
            r_obnum   <= r_bnum;
            r_obrange <= r_brange;
            r_obint   <= r_bint;
            r_oempty  <= r_empty;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_kept          = r_okept;
    assign o_reject_code   = r_ocode;
    assign o_bin_number    = r_obnum;
    assign o_bin_range_mm  = r_obrange;
    assign o_bin_intensity = r_obint;
    assign o_bin_empty     = r_oempty;

endmodule

// File: hdl/pcsb_chk.sv
// Port-level checker for the point-to-scan binner, bound to the top level.
// Depends on pcsb_pkg.
module pcsb_chk
    import pcsb_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_ready,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input logic            o_kept,
    input logic [2:0]      o_reject_code,
    input logic            o_bin_empty
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // one transaction in flight: busy after accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("accepted a second transaction while busy");

    // a kept point passes or lands beyond the store
    a_kept_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kept |-> o_reject_code == RJ_PASS || o_reject_code == RJ_BEYOND)
        else $error("kept point with a filter reject code");

    // an empty bin answer never comes from a point
    a_empty_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bin_empty |-> !o_kept)
        else $error("empty flag on a kept point");

endmodule

bind point_cloud_to_scan_binner pcsb_chk u_pcsb_chk (.*);
